// ===== rtl/mch_pkg.sv =====
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file of the block except mch_ram imports this package.
package mch_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 8;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CORR_W     = 17;
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned ANG_W      = 25;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned HEAD_W     = 19;

  localparam logic [SAMPLE_W-1:0] RST_Y_SCALE = 16'd59040;
  localparam logic [OFFSET_W-1:0] RST_OFFSET  = 9'd95;

  // Quarter turn in 1/256 centidegree
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd2304000;

  localparam logic signed [HEAD_W-1:0] HALF_TURN_CD = 19'sd18000;
  localparam logic signed [HEAD_W-1:0] TWO_TURN_CD  = 19'sd72000;
  localparam logic [HEAD_W-1:0] ONE_TURN_U   = 19'd36000;
  localparam logic [HEAD_W-1:0] TWO_TURN_U   = 19'd72000;
  localparam logic [HEAD_W-1:0] THREE_TURN_U = 19'd108000;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X       = 2'd0,
    CFG_ORIGIN_Y       = 2'd1,
    CFG_Y_SCALE        = 2'd2,
    CFG_HEADING_OFFSET = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_WIN,
    ST_CORD,
    ST_FIN,
    ST_OUT
  } mch_state_e;

  // atan(2^-i) in 1/256 centidegree, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 25'sd1152000;
      5'd1:    val = 25'sd680065;
      5'd2:    val = 25'sd359328;
      5'd3:    val = 25'sd182400;
      5'd4:    val = 25'sd91554;
      5'd5:    val = 25'sd45822;
      5'd6:    val = 25'sd22916;
      5'd7:    val = 25'sd11459;
      5'd8:    val = 25'sd5730;
      5'd9:    val = 25'sd2865;
      5'd10:   val = 25'sd1432;
      5'd11:   val = 25'sd716;
      5'd12:   val = 25'sd358;
      5'd13:   val = 25'sd179;
      5'd14:   val = 25'sd90;
      5'd15:   val = 25'sd45;
      5'd16:   val = 25'sd22;
      5'd17:   val = 25'sd11;
      5'd18:   val = 25'sd6;
      5'd19:   val = 25'sd3;
      5'd20:   val = 25'sd1;
      5'd21:   val = 25'sd1;
      default: val = 25'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/mch_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module mch_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mch_window.sv =====
// Moving window of corrected samples: two window RAMs, per-entry valid bits and running sums.
// Depends on mch_pkg and mch_ram.
module mch_window
  import mch_pkg::*;
#(
  parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned SUM_W = CORR_W + $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CORR_W-1:0] cx_i,
  input  logic signed [CORR_W-1:0] cy_i,
  output logic                     done_o,
  output logic signed [SUM_W-1:0]  sum_x_o,
  output logic signed [SUM_W-1:0]  sum_y_o
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);

  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [DEPTH-1:0]         vld_q;
  logic                     upd_q;
  logic                     done_q;
  logic signed [CORR_W-1:0] cx_q, cy_q;
  logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
  logic [CORR_W-1:0]        old_x_raw, old_y_raw;
  logic signed [CORR_W-1:0] old_x, old_y;

  // Read the retiring entry on start, write the new one in the following cycle
  mch_ram #(.WIDTH(CORR_W), .DEPTH(DEPTH)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (upd_q),
    .waddr_i (slot_q),
    .wdata_i (cx_q),
    .re_i    (start_i),
    .raddr_i (slot_q),
    .rdata_o (old_x_raw)
  );

  mch_ram #(.WIDTH(CORR_W), .DEPTH(DEPTH)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (upd_q),
    .waddr_i (slot_q),
    .wdata_i (cy_q),
    .re_i    (start_i),
    .raddr_i (slot_q),
    .rdata_o (old_y_raw)
  );

  // Never-written entries read as zero
  assign old_x = vld_q[slot_q] ? $signed(old_x_raw) : '0;
  assign old_y = vld_q[slot_q] ? $signed(old_y_raw) : '0;

  assign slot_d = (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      vld_q   <= '0;
      upd_q   <= 1'b0;
      done_q  <= 1'b0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else begin
      upd_q  <= start_i;
      done_q <= upd_q;
      if (upd_q) begin
        sum_x_q       <= sum_x_q + SUM_W'(cx_q) - SUM_W'(old_x);
        sum_y_q       <= sum_y_q + SUM_W'(cy_q) - SUM_W'(old_y);
        vld_q[slot_q] <= 1'b1;
        slot_q        <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cx_q <= cx_i;
      cy_q <= cy_i;
    end
  end

  assign done_o  = done_q;
  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;

endmodule

// ===== rtl/mch_cordic.sv =====
// Iterative vectoring CORDIC: angle of (x, y) in 1/256 centidegree, one step per cycle.
// Depends on mch_pkg for the arctangent table and angle width.
module mch_cordic
  import mch_pkg::*;
#(
  parameter int unsigned SUM_W = CORR_W + 3,
  parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] x_i,
  input  logic signed [SUM_W-1:0] y_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] ang_o
);

  localparam int unsigned CW    = SUM_W + 10;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [CW-1:0]    x_q, y_q, x_d, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic signed [CW-1:0]    xs, ys, dx, dy;
  logic signed [CW-1:0]    px, py;
  logic signed [ANG_W-1:0] pz;
  logic signed [ANG_W-1:0] at;
  logic                    is_zero;
  logic                    last;

  assign is_zero = (x_i == '0) && (y_i == '0);
  assign xs      = CW'(x_i) <<< 8;
  assign ys      = CW'(y_i) <<< 8;

  // Pre-rotate by a quarter turn when the vector lies in the left half-plane
  always_comb begin
    px = xs;
    py = ys;
    pz = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        px = ys;
        py = -xs;
        pz = QUARTER_TURN;
      end else begin
        px = -ys;
        py = xs;
        pz = -QUARTER_TURN;
      end
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = atan_lookup(ATAN_IDX_W'(cnt_q));

  always_comb begin
    if (y_q >= 0) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end
  end

  assign last = (cnt_q == CNT_W'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !is_zero;
        done_q <= is_zero;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= px;
      y_q <= py;
      z_q <= is_zero ? '0 : pz;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign ang_o  = z_q;

endmodule

// ===== rtl/magnetic_compass_heading.sv =====
// Compass heading from raw two-axis magnetometer samples: top level with sequencer.
// Depends on mch_pkg, mch_ram (through mch_window), mch_window and mch_cordic.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one raw x/y sample per request.
//   Output channel (out_valid_o / out_stall_i) returns one heading per request,
//   0..35999 centidegrees. A transfer happens on a clock edge with valid high
//   and stall low.
//   Configuration port (cfg_valid_i / cfg_ready_o) writes the hard-iron origins,
//   the y soft-iron scale and the declination offset by index; it is always ready.
//   Write it only while no request is in flight.
// Sequencing:
//   One request is processed at a time: after acceptance the sample passes
//   through correction, the window update, the CORDIC iterations and the
//   heading step before it is loaded into the output register, and the next
//   request is taken once that load is done. A zero mean vector skips the
//   iterations.
// Reset:
//   Clears the window (all entries read as zero), the running sums and the slot
//   pointer, and loads the register defaults.
// Backpressure:
//   A finished heading waits in the output register. The next request is
//   accepted and processed meanwhile; it holds in its last step until the
//   output register is free.
module magnetic_compass_heading
  import mch_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] mag_x_raw_i,
  input  logic [SAMPLE_W-1:0] mag_y_raw_i,
  // heading result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] heading_centideg_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [SAMPLE_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W = CORR_W + $clog2(WINDOW_DEPTH);

  // Configuration registers
  logic signed [SAMPLE_W-1:0] origin_x_q, origin_y_q;
  logic [SAMPLE_W-1:0]        y_scale_q;
  logic [OFFSET_W-1:0]        offset_q;

  // Sequencer and datapath registers
  mch_state_e          state_q, state_d;
  logic [SAMPLE_W-1:0] raw_x_q, raw_y_q;
  logic [HEAD_W-1:0]   hp_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] heading_q;

  // Sequencer outputs
  logic in_acc;
  logic win_start;
  logic cord_start;
  logic hp_load;
  logic out_load;
  logic out_free;

  // Datapath nets
  logic signed [CORR_W-1:0]   cx, dy, cy;
  logic [CORR_W-1:0]          mag;
  logic [CORR_W+SAMPLE_W-1:0] prod;
  logic [CORR_W-1:0]          cy_mag;
  logic                       win_done;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic                       cord_done;
  logic signed [ANG_W-1:0]    ang;
  logic signed [ANG_W-1:0]    ang_rnd;
  logic signed [ANG_W-9:0]    deg_c;
  logic [15:0]                off_cd;
  logic signed [HEAD_W-1:0]   h, hp;
  logic [HEAD_W-1:0]          wrapped;

  // ---------------------------------------------------------------------------
  // Configuration writes: always accepted, register picked by index
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      y_scale_q  <= RST_Y_SCALE;
      offset_q   <= RST_OFFSET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ORIGIN_X:       origin_x_q <= $signed(cfg_data_i);
        CFG_ORIGIN_Y:       origin_y_q <= $signed(cfg_data_i);
        CFG_Y_SCALE:        y_scale_q  <= cfg_data_i;
        CFG_HEADING_OFFSET: offset_q   <= cfg_data_i[OFFSET_W-1:0];
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: one request at a time
  // ---------------------------------------------------------------------------
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CORR;
      ST_CORR: state_d = ST_WIN;
      ST_WIN:  if (win_done) state_d = ST_CORD;
      ST_CORD: if (cord_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    win_start  = 1'b0;
    cord_start = 1'b0;
    hp_load    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_CORR: win_start  = 1'b1;
      ST_WIN:  cord_start = win_done;
      ST_CORD: ;
      ST_FIN:  hp_load    = 1'b1;
      ST_OUT:  out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the raw sample on acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_x_q <= mag_x_raw_i;
      raw_y_q <= mag_y_raw_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Hard- and soft-iron correction; y scaled by magnitude so it truncates
  // toward zero. The window registers the corrected pair.
  // ---------------------------------------------------------------------------
  assign cx     = CORR_W'($signed(raw_x_q)) - CORR_W'(origin_x_q);
  assign dy     = CORR_W'($signed(raw_y_q)) - CORR_W'(origin_y_q);
  assign mag    = dy[CORR_W-1] ? CORR_W'(-dy) : CORR_W'(dy);
  assign prod   = (CORR_W+SAMPLE_W)'(mag) * (CORR_W+SAMPLE_W)'(y_scale_q);
  assign cy_mag = prod[CORR_W+SAMPLE_W-1:SAMPLE_W];
  assign cy     = dy[CORR_W-1] ? -$signed(cy_mag) : $signed(cy_mag);

  mch_window #(.DEPTH(WINDOW_DEPTH), .SUM_W(SUM_W)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (win_start),
    .cx_i    (cx),
    .cy_i    (cy),
    .done_o  (win_done),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y)
  );

  // Direction of the window sums; a common divisor leaves the angle unchanged
  mch_cordic #(.SUM_W(SUM_W), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (sum_x),
    .y_i     (sum_y),
    .done_o  (cord_done),
    .ang_o   (ang)
  );

  // ---------------------------------------------------------------------------
  // Heading: round angle to centidegrees (half up), subtract from 180 deg and
  // the declination, bias by two turns to stay positive.
  // ---------------------------------------------------------------------------
  assign ang_rnd = ang + ANG_W'(128);
  assign deg_c   = ang_rnd[ANG_W-1:8];
  assign off_cd  = 16'(offset_q) * 16'd100;
  assign h       = HALF_TURN_CD - HEAD_W'(deg_c) - HEAD_W'(off_cd);
  assign hp      = h + TWO_TURN_CD;

  always_ff @(posedge clk_i) begin
    if (hp_load) begin
      hp_q <= HEAD_W'(hp);
    end
  end

  // Fold the biased heading back into one turn
  always_comb begin
    if (hp_q >= THREE_TURN_U) begin
      wrapped = hp_q - THREE_TURN_U;
    end else if (hp_q >= TWO_TURN_U) begin
      wrapped = hp_q - TWO_TURN_U;
    end else if (hp_q >= ONE_TURN_U) begin
      wrapped = hp_q - ONE_TURN_U;
    end else begin
      wrapped = hp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop valid once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      heading_q <= wrapped[SAMPLE_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign heading_centideg_o = heading_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the output step");

  a_win_done_in_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done |-> (state_q == ST_WIN))
    else $error("window update finished outside its step");

  a_cord_done_in_cord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == ST_CORD))
    else $error("CORDIC finished outside its step");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (heading_q < ONE_TURN_U[SAMPLE_W-1:0]))
    else $error("heading outside one turn");

endmodule
